@@ rtl/ipv4dq_pkg.sv @@
// shared types and constants for the ipv4 dotted-quad parser
package ipv4dq_pkg;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDot  = 8'h2e;

  localparam logic [9:0] OctetMax   = 10'h0ff;
  localparam logic [1:0] DigitsMax  = 2'd3;
  localparam logic [2:0] UpperCount = 3'd3;

  typedef struct packed {
    logic [9:0]  octet_value;
    logic [1:0]  digit_count;
    logic [2:0]  octets_done;
    logic        leading_zero;
    logic        error_seen;
    logic [23:0] upper_octets;
  } parse_state_t;

endpackage

@@ rtl/ipv4dq_char_if.sv @@
// input channel: one text character per transfer with a last flag
interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink (input valid, input text_char, input last, output ready);
endinterface

@@ rtl/ipv4dq_addr_if.sv @@
// output channel: parsed address and valid flag per transfer
interface ipv4dq_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        valid_res;

  modport source (output valid, output address, output valid_res, input ready);
  modport sink (input valid, input address, input valid_res, output ready);
endinterface

@@ rtl/ipv4dq_step.sv @@
// next parse state for one character and the result it would give at end of string
module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t state_i,
  input  logic [7:0]               text_char_i,
  output ipv4dq_pkg::parse_state_t state_o,
  output logic [31:0]              address_o,
  output logic                     valid_res_o
);

  logic       is_digit;
  logic       is_dot;
  logic [3:0] digit;
  logic [9:0] times_ten;
  logic       ok;

  assign is_digit  = (text_char_i >= ipv4dq_pkg::CharZero) &&
                     (text_char_i <= ipv4dq_pkg::CharNine);
  assign is_dot    = (text_char_i == ipv4dq_pkg::CharDot);
  assign digit     = 4'(text_char_i - ipv4dq_pkg::CharZero);
  // value * 10 as shift-and-add, wraps at 10 bits
  assign times_ten = {state_i.octet_value[6:0], 3'b000} +
                     {state_i.octet_value[8:0], 1'b0};

  always_comb begin
    state_o = state_i;
    if (!state_i.error_seen) begin
      if (is_digit) begin
        if (state_i.digit_count == ipv4dq_pkg::DigitsMax) begin
          state_o.error_seen = 1'b1;
        end else if (state_i.digit_count != 2'd0 && state_i.leading_zero) begin
          state_o.error_seen = 1'b1;
        end else begin
          if (state_i.digit_count == 2'd0) begin
            state_o.leading_zero = (digit == 4'd0);
          end
          state_o.octet_value = times_ten + {6'd0, digit};
          state_o.digit_count = state_i.digit_count + 2'd1;
        end
      end else if (is_dot) begin
        if (state_i.digit_count == 2'd0 || state_i.octet_value > ipv4dq_pkg::OctetMax ||
            state_i.octets_done >= ipv4dq_pkg::UpperCount) begin
          state_o.error_seen = 1'b1;
        end else begin
          state_o.upper_octets = {state_i.upper_octets[15:0], state_i.octet_value[7:0]};
          state_o.octets_done  = state_i.octets_done + 3'd1;
          state_o.octet_value  = '0;
          state_o.digit_count  = '0;
          state_o.leading_zero = 1'b0;
        end
      end else begin
        state_o.error_seen = 1'b1;
      end
    end
  end

  assign ok = !state_o.error_seen && (state_o.octets_done == ipv4dq_pkg::UpperCount) &&
              (state_o.digit_count != 2'd0) && (state_o.octet_value <= ipv4dq_pkg::OctetMax);
  assign address_o   = ok ? {state_o.upper_octets, state_o.octet_value[7:0]} : 32'd0;
  assign valid_res_o = ok;

endmodule

@@ rtl/ipv4_dotted_quad_parse.sv @@
// ipv4 dotted-quad parser top level
// one character accepted per cycle, sustained, while the result side keeps up
// after the last character's transfer the result passes through the input register,
// then through the parse-state update into the result register
// the parse state is a single set of registers updated once per character
// reset clears the input and result valid flags and the parse state; the
// parse state also returns to zero after each last character
module ipv4_dotted_quad_parse (
  input logic          clk_i,
  input logic          rst_ni,
  ipv4dq_char_if.sink  char_i,
  ipv4dq_addr_if.source addr_o
);

  logic                     in_valid_q;
  logic [7:0]               in_char_q;
  logic                     in_last_q;
  logic                     in_adv;
  logic                     out_free;

  ipv4dq_pkg::parse_state_t state_q, state_d;
  logic [31:0]              step_address;
  logic                     step_valid_res;

  logic                     out_valid_q;
  logic [31:0]              out_address_q;
  logic                     out_valid_res_q;

  assign out_free     = !out_valid_q || addr_o.ready;
  // a character without last never needs the result register
  assign in_adv       = in_valid_q && (!in_last_q || out_free);
  assign char_i.ready = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      in_char_q <= char_i.text_char;
      in_last_q <= char_i.last;
    end
  end

  ipv4dq_step u_step (
    .state_i     (state_q),
    .text_char_i (in_char_q),
    .state_o     (state_d),
    .address_o   (step_address),
    .valid_res_o (step_valid_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_adv) begin
      state_q <= in_last_q ? '0 : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (addr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_last_q) begin
      out_address_q   <= step_address;
      out_valid_res_q <= step_valid_res;
    end
  end

  assign addr_o.valid     = out_valid_q;
  assign addr_o.address   = out_address_q;
  assign addr_o.valid_res = out_valid_res_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_valid_res_q) |-> (out_address_q == 32'd0))
    else $error("rejected string gives a nonzero address");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && in_last_q) |=> (state_q == '0))
    else $error("parse state not cleared after end of string");

  a_octets_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.octets_done <= ipv4dq_pkg::UpperCount)
    else $error("more than three completed octets");

  a_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.leading_zero && state_q.digit_count >= 2'd2 && !state_q.error_seen))
    else $error("multi-digit octet with leading zero not flagged");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !addr_o.ready) |-> !(in_adv && in_last_q))
    else $error("pending result overwritten");

endmodule

@@ tb/ipv4dq_addr_predict.sv @@
// checker for the dotted-quad parser: predicts each parsed address and compares it
`timescale 1ns / 100ps

module ipv4dq_addr_predict (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4dq_char_if        char_mon,
  ipv4dq_addr_if        addr_mon,
  output int            fail_count_o,
  output int            pending_o
);

  typedef struct packed {
    logic [31:0] address;
    logic        valid_res;
  } parsed_addr_t;

  ipv4dq_pkg::parse_state_t parse_st;
  parsed_addr_t             addr_expect_q[$];
  int                       fails;

  // an octet can be closed only if it has digits and fits in a byte
  function automatic logic octet_closable(ipv4dq_pkg::parse_state_t s);
    return (s.digit_count != 2'd0) && (s.octet_value <= ipv4dq_pkg::OctetMax);
  endfunction

  function automatic ipv4dq_pkg::parse_state_t advance_parse(ipv4dq_pkg::parse_state_t s,
                                                             logic [7:0] ch);
    ipv4dq_pkg::parse_state_t n;
    logic [9:0]               digit;
    n = s;
    digit = {2'b00, 8'(ch - ipv4dq_pkg::CharZero)};
    // once an error is latched the rest of the text is ignored
    if (s.error_seen) return n;
    if (ch >= ipv4dq_pkg::CharZero && ch <= ipv4dq_pkg::CharNine) begin
      if (s.digit_count >= ipv4dq_pkg::DigitsMax) begin
        n.error_seen = 1'b1;
      end else if (s.digit_count != 2'd0 && s.leading_zero) begin
        n.error_seen = 1'b1;
      end else begin
        if (s.digit_count == 2'd0) n.leading_zero = (digit == 10'd0);
        n.octet_value = 10'(s.octet_value * 10'd10 + digit);
        n.digit_count = s.digit_count + 2'd1;
      end
    end else if (ch == ipv4dq_pkg::CharDot) begin
      if (!octet_closable(s) || s.octets_done >= ipv4dq_pkg::UpperCount) begin
        n.error_seen = 1'b1;
      end else begin
        n.upper_octets = {s.upper_octets[15:0], s.octet_value[7:0]};
        n.octets_done  = s.octets_done + 3'd1;
        n.octet_value  = '0;
        n.digit_count  = '0;
        n.leading_zero = 1'b0;
      end
    end else begin
      n.error_seen = 1'b1;
    end
    return n;
  endfunction

  function automatic parsed_addr_t finish_parse(ipv4dq_pkg::parse_state_t s);
    parsed_addr_t r;
    r.valid_res = !s.error_seen && s.octets_done == ipv4dq_pkg::UpperCount &&
                  octet_closable(s);
    r.address   = r.valid_res ? {s.upper_octets, s.octet_value[7:0]} : 32'd0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_addr_t exp_res;
    if (!rst_ni) begin
      parse_st = '0;
      addr_expect_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (addr_mon.valid && addr_mon.ready) begin
        if (addr_expect_q.size() == 0) begin
          $display("%0t: unexpected result transfer address=%h valid_res=%b", $time,
                   addr_mon.address, addr_mon.valid_res);
          fails++;
        end else begin
          exp_res = addr_expect_q.pop_front();
          if (addr_mon.address !== exp_res.address) begin
            $display("%0t: address mismatch expected=%h actual=%h", $time,
                     exp_res.address, addr_mon.address);
            fails++;
          end
          if (addr_mon.valid_res !== exp_res.valid_res) begin
            $display("%0t: valid_res mismatch expected=%b actual=%b", $time,
                     exp_res.valid_res, addr_mon.valid_res);
            fails++;
          end
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        parse_st = advance_parse(parse_st, char_mon.text_char);
        if (char_mon.last) begin
          addr_expect_q.push_back(finish_parse(parse_st));
          parse_st = '0;
        end
      end
      fail_count_o <= fails;
      pending_o <= addr_expect_q.size();
    end
  end

endmodule

@@ tb/tb_ipv4_dotted_quad_parse.sv @@
// testbench top for the dotted-quad parser: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_ipv4_dotted_quad_parse;

  typedef logic [7:0] text_t[$];

  localparam int CharTarget = 1500;
  localparam int IdleLimit  = 1000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   chars_sent;
  int   burst_left;
  int   idle_cycles;

  ipv4dq_char_if char_if ();
  ipv4dq_addr_if addr_if ();

  ipv4_dotted_quad_parse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .addr_o (addr_if)
  );

  ipv4dq_addr_predict addr_predict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_mon     (char_if),
    .addr_mon     (addr_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic text_t text_bytes(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic void append_dec(ref text_t t, input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic int unsigned pick_octet();
    int unsigned edge_vals[6] = '{0, 255, 9, 10, 99, 100};
    if ($urandom_range(0, 3) == 0) return edge_vals[$urandom_range(0, 5)];
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return ipv4dq_pkg::CharDot;
      1:       return 8'($urandom_range(0, 255));
      default: return ipv4dq_pkg::CharZero + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // mostly well-formed quads with random octets; the rest are flawed or noise
  function automatic text_t build_quad();
    text_t       t;
    int unsigned flaw;
    int unsigned n_oct;
    int unsigned bad_idx;
    int unsigned pos;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 20)) t.push_back(pick_char());
      return t;
    end
    flaw = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 8) : 0;
    n_oct = 4;
    if (flaw == 1) n_oct = $urandom_range(0, 1) ? 5 : $urandom_range(1, 3);
    bad_idx = $urandom_range(0, n_oct - 1);
    for (int i = 0; i < n_oct; i++) begin
      if (i == bad_idx && flaw == 2) begin
        t.push_back(ipv4dq_pkg::CharZero);
        append_dec(t, $urandom_range(0, 99));
      end else if (i == bad_idx && flaw == 3) begin
        append_dec(t, $urandom_range(256, 999));
      end else if (i == bad_idx && flaw == 4) begin
        append_dec(t, $urandom_range(1000, 9999));
      end else begin
        append_dec(t, pick_octet());
      end
      if (i != n_oct - 1) t.push_back(ipv4dq_pkg::CharDot);
    end
    pos = $urandom_range(0, t.size() - 1);
    case (flaw)
      5: t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
      6: if (t.size() > 1) t.delete(pos);
      7: t.insert($urandom_range(0, t.size()), ipv4dq_pkg::CharDot);
      8: t[pos] = 8'($urandom_range(0, 255));
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_char(logic [7:0] ch, logic is_last);
    char_if.valid     <= 1'b1;
    char_if.text_char <= ch;
    char_if.last      <= is_last;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
    // bursts of random length, then a short gap with valid low
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_text(text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  // result side: alternating runs of ready and stall, with long ready stretches
  initial begin
    logic ready_lvl;
    int   run_left;
    ready_lvl = 1'b0;
    run_left = 0;
    addr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        ready_lvl = !ready_lvl;
        if (ready_lvl) begin
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 10);
        end else begin
          run_left = $urandom_range(1, 8);
        end
      end
      run_left--;
      addr_if.ready <= ready_lvl;
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (char_if.valid && char_if.ready) || (addr_if.valid && addr_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    text_t t;
    chars_sent = 0;
    burst_left = 0;
    rst_ni <= 1'b0;
    char_if.valid <= 1'b0;
    char_if.text_char <= 8'h00;
    char_if.last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(text_bytes("0.0.0.0"));
    send_text(text_bytes("255.255.255.255"));
    send_text(text_bytes("10.0.199.9"));
    send_text(text_bytes("1.2.3.x"));
    send_text(text_bytes("/1.2.3.4"));
    send_text(text_bytes("1.2.3.4:"));
    send_text(text_bytes("1-2.3.4"));
    t = text_bytes("1.2.3.");
    t.push_back(8'hff);
    send_text(t);
    t = text_bytes("8.8.");
    t.push_back(8'h80);
    t.push_back(ipv4dq_pkg::CharZero + 8'd8);
    send_text(t);
    t = {8'h00};
    send_text(t);
    send_text(text_bytes("1234.1.1.1"));
    send_text(text_bytes("01.1.1.1"));
    send_text(text_bytes("1.2.3.04"));
    send_text(text_bytes(".1.1.1"));
    send_text(text_bytes("1..1.1"));
    send_text(text_bytes("1.1.1."));
    send_text(text_bytes("256.1.1.1"));
    send_text(text_bytes("1.1.1.999"));
    send_text(text_bytes("1.1.1.1.1"));
    send_text(text_bytes("1.1.1"));
    send_text(text_bytes("5"));
    send_text(text_bytes("."));
    // error early, then a well-formed tail that must still be ignored
    send_text(text_bytes("a1.2.3.4"));

    while (chars_sent < CharTarget) send_text(build_quad());

    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
